### rtl/class_file_stream_parser_assert.svh
// Assertion macros used by the class file parser checker
`ifndef CLASS_FILE_STREAM_PARSER_ASSERT_SVH
`define CLASS_FILE_STREAM_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define CFSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfsp assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define CFSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfsp assertion failed");

`endif

### rtl/cfsp_pkg.sv
// Types and constants for the class file stream parser
`timescale 1ns / 1ps

package cfsp_pkg;

  localparam logic [31:0] MAGIC_WORD = 32'hCAFEBABE;

  localparam logic [7:0] TAG_UTF8        = 8'd1;
  localparam logic [7:0] TAG_CLASS       = 8'd7;
  localparam logic [7:0] TAG_FIELDREF    = 8'd9;
  localparam logic [7:0] TAG_METHODREF   = 8'd10;
  localparam logic [7:0] TAG_NAMEANDTYPE = 8'd12;

  localparam logic [4:0] KIND_MAGIC         = 5'd0;
  localparam logic [4:0] KIND_MINOR         = 5'd1;
  localparam logic [4:0] KIND_MAJOR         = 5'd2;
  localparam logic [4:0] KIND_CP_COUNT      = 5'd3;
  localparam logic [4:0] KIND_TAG           = 5'd4;
  localparam logic [4:0] KIND_NAME_INDEX    = 5'd5;
  localparam logic [4:0] KIND_CLASS_INDEX   = 5'd6;
  localparam logic [4:0] KIND_NAT_INDEX     = 5'd7;
  localparam logic [4:0] KIND_DESC_INDEX    = 5'd8;
  localparam logic [4:0] KIND_UTF8_LEN      = 5'd9;
  localparam logic [4:0] KIND_UTF8_BYTE     = 5'd10;
  localparam logic [4:0] KIND_ACCESS        = 5'd11;
  localparam logic [4:0] KIND_THIS          = 5'd12;
  localparam logic [4:0] KIND_SUPER         = 5'd13;
  localparam logic [4:0] KIND_IF_COUNT      = 5'd14;
  localparam logic [4:0] KIND_IFACE         = 5'd15;
  localparam logic [4:0] KIND_FIELDS_COUNT  = 5'd16;
  localparam logic [4:0] KIND_METHODS_COUNT = 5'd17;
  localparam logic [4:0] KIND_MEMBER_ACCESS = 5'd18;
  localparam logic [4:0] KIND_ATTR_COUNT    = 5'd19;
  localparam logic [4:0] KIND_ATTR_NAME     = 5'd20;
  localparam logic [4:0] KIND_ATTR_LEN      = 5'd21;
  localparam logic [4:0] KIND_ATTR_BYTE     = 5'd22;
  localparam logic [4:0] KIND_STATUS        = 5'd23;

  localparam logic [2:0] ST_RUNNING   = 3'd0;
  localparam logic [2:0] ST_FINISHED  = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_CUT_OFF   = 3'd3;
  localparam logic [2:0] ST_BAD_TAG   = 3'd4;

  localparam logic [1:0] OWN_NONE   = 2'd0;
  localparam logic [1:0] OWN_FIELD  = 2'd1;
  localparam logic [1:0] OWN_METHOD = 2'd2;
  localparam logic [1:0] OWN_CLASS  = 2'd3;

  typedef enum logic [4:0] {
    PH_MAGIC, PH_MINOR, PH_MAJOR, PH_CPCOUNT, PH_TAG, PH_CPA, PH_CPB,
    PH_UTFLEN, PH_UTFBYTES, PH_ACCESS, PH_THIS, PH_SUPER, PH_IFCOUNT,
    PH_IFACE, PH_FCOUNT, PH_MCOUNT, PH_MACCESS, PH_MNAME, PH_MDESC,
    PH_MACOUNT, PH_CACOUNT, PH_ANAME, PH_ALEN, PH_ABYTES, PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } cfsp_in_t;

  typedef struct packed {
    logic [4:0]  item_kind;
    logic [31:0] item_value;
    logic [15:0] entry_number;
    logic [1:0]  owner;
    logic [2:0]  status;
  } cfsp_out_t;

  // bytes per field in each phase
  function automatic logic [2:0] phase_width(phase_t p);
    logic [2:0] w;
    case (p)
      PH_MAGIC, PH_ALEN:                w = 3'd4;
      PH_TAG, PH_UTFBYTES, PH_ABYTES:   w = 3'd1;
      default:                          w = 3'd2;
    endcase
    return w;
  endfunction

endpackage

### rtl/cfsp_walker.sv
// Layout walker: phase and counter state plus per-byte decode
`timescale 1ns / 1ps

module cfsp_walker import cfsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  cfsp_in_t  beat,
  output logic      res_valid,
  output cfsp_out_t res
);

  phase_t      phase, phase_next;
  logic [1:0]  byte_position, byte_position_next;
  logic [31:0] accumulator, accumulator_next;
  logic [15:0] entries_left, entries_left_next;
  logic [15:0] entry_counter, entry_counter_next;
  logic [15:0] members_left, members_left_next;
  logic [15:0] attributes_left, attributes_left_next;
  logic [15:0] member_index, member_index_next;
  logic [31:0] payload_left, payload_left_next;
  logic [7:0]  current_tag, current_tag_next;
  logic        stopped, stopped_next;
  logic [1:0]  ctx_owner, ctx_owner_next;

  logic [31:0] acc_sh;
  logic [1:0]  bp_inc;
  logic        complete;
  logic [15:0] v16;
  logic [15:0] el_dec, al_dec, ml_dec, ec_inc, mi_inc;
  logic [31:0] pl_dec;
  phase_t      ae_phase;
  logic        have;
  logic [2:0]  st;

  assign acc_sh   = {accumulator[23:0], beat.data_byte};
  assign bp_inc   = byte_position + 2'd1;
  assign complete = (bp_inc == 2'd0) || ({1'b0, bp_inc} >= phase_width(phase));
  assign v16      = acc_sh[15:0];
  assign el_dec   = (entries_left != '0) ? entries_left - 16'd1 : '0;
  assign al_dec   = (attributes_left != '0) ? attributes_left - 16'd1 : '0;
  assign ml_dec   = (members_left != '0) ? members_left - 16'd1 : '0;
  assign pl_dec   = (payload_left != '0) ? payload_left - 32'd1 : '0;
  assign ec_inc   = entry_counter + 16'd1;
  assign mi_inc   = member_index + 16'd1;

  // where a finished attribute table leads
  always_comb begin
    if (ctx_owner == OWN_CLASS) begin
      ae_phase = PH_DONE;
    end else if (ml_dec != '0) begin
      ae_phase = PH_MACCESS;
    end else if (ctx_owner == OWN_FIELD) begin
      ae_phase = PH_MCOUNT;
    end else begin
      ae_phase = PH_CACOUNT;
    end
  end

  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    accumulator_next     = accumulator;
    entries_left_next    = entries_left;
    entry_counter_next   = entry_counter;
    members_left_next    = members_left;
    attributes_left_next = attributes_left;
    member_index_next    = member_index;
    payload_left_next    = payload_left;
    current_tag_next     = current_tag;
    stopped_next         = stopped;
    ctx_owner_next       = ctx_owner;
    res                  = '0;
    res.item_kind        = KIND_STATUS;
    have                 = 1'b0;
    st                   = ST_RUNNING;

    if (accept && !stopped) begin
      if (complete) begin
        byte_position_next = '0;
        accumulator_next   = '0;
        have               = 1'b1;
        res.item_value     = acc_sh;
        unique case (phase)
          PH_MAGIC: begin
            res.item_kind = KIND_MAGIC;
            if (acc_sh != MAGIC_WORD) begin
              st = ST_BAD_MAGIC;
            end else begin
              phase_next = PH_MINOR;
            end
          end
          PH_MINOR: begin
            res.item_kind = KIND_MINOR;
            phase_next    = PH_MAJOR;
          end
          PH_MAJOR: begin
            res.item_kind = KIND_MAJOR;
            phase_next    = PH_CPCOUNT;
          end
          PH_CPCOUNT: begin
            res.item_kind      = KIND_CP_COUNT;
            entry_counter_next = 16'd1;
            if (v16 > 16'd1) begin
              entries_left_next = v16 - 16'd1;
              phase_next        = PH_TAG;
            end else begin
              entries_left_next = '0;
              phase_next        = PH_ACCESS;
            end
          end
          PH_TAG: begin
            res.item_kind    = KIND_TAG;
            res.entry_number = entry_counter;
            current_tag_next = beat.data_byte;
            case (beat.data_byte) inside
              TAG_CLASS, TAG_FIELDREF, TAG_METHODREF, TAG_NAMEANDTYPE: phase_next = PH_CPA;
              TAG_UTF8: phase_next = PH_UTFLEN;
              default:  st = ST_BAD_TAG;
            endcase
          end
          PH_CPA: begin
            res.entry_number = entry_counter;
            if (current_tag == TAG_CLASS) begin
              res.item_kind      = KIND_NAME_INDEX;
              entry_counter_next = ec_inc;
              entries_left_next  = el_dec;
              phase_next         = (el_dec == '0) ? PH_ACCESS : PH_TAG;
            end else if (current_tag == TAG_NAMEANDTYPE) begin
              res.item_kind = KIND_NAME_INDEX;
              phase_next    = PH_CPB;
            end else begin
              res.item_kind = KIND_CLASS_INDEX;
              phase_next    = PH_CPB;
            end
          end
          PH_CPB: begin
            res.entry_number   = entry_counter;
            res.item_kind      = (current_tag == TAG_NAMEANDTYPE) ? KIND_DESC_INDEX
                                                                  : KIND_NAT_INDEX;
            entry_counter_next = ec_inc;
            entries_left_next  = el_dec;
            phase_next         = (el_dec == '0) ? PH_ACCESS : PH_TAG;
          end
          PH_UTFLEN: begin
            res.item_kind     = KIND_UTF8_LEN;
            res.entry_number  = entry_counter;
            payload_left_next = {16'd0, v16};
            if (v16 == '0) begin
              entry_counter_next = ec_inc;
              entries_left_next  = el_dec;
              phase_next         = (el_dec == '0) ? PH_ACCESS : PH_TAG;
            end else begin
              phase_next = PH_UTFBYTES;
            end
          end
          PH_UTFBYTES: begin
            res.item_kind     = KIND_UTF8_BYTE;
            res.entry_number  = entry_counter;
            payload_left_next = pl_dec;
            if (pl_dec == '0) begin
              entry_counter_next = ec_inc;
              entries_left_next  = el_dec;
              phase_next         = (el_dec == '0) ? PH_ACCESS : PH_TAG;
            end
          end
          PH_ACCESS: begin
            res.item_kind = KIND_ACCESS;
            phase_next    = PH_THIS;
          end
          PH_THIS: begin
            res.item_kind = KIND_THIS;
            phase_next    = PH_SUPER;
          end
          PH_SUPER: begin
            res.item_kind = KIND_SUPER;
            phase_next    = PH_IFCOUNT;
          end
          PH_IFCOUNT: begin
            res.item_kind      = KIND_IF_COUNT;
            entries_left_next  = v16;
            entry_counter_next = '0;
            phase_next         = (v16 == '0) ? PH_FCOUNT : PH_IFACE;
          end
          PH_IFACE: begin
            res.item_kind      = KIND_IFACE;
            res.entry_number   = entry_counter;
            entry_counter_next = ec_inc;
            entries_left_next  = el_dec;
            if (el_dec == '0) phase_next = PH_FCOUNT;
          end
          PH_FCOUNT: begin
            res.item_kind     = KIND_FIELDS_COUNT;
            res.owner         = OWN_FIELD;
            ctx_owner_next    = OWN_FIELD;
            members_left_next = v16;
            member_index_next = '0;
            phase_next        = (v16 == '0) ? PH_MCOUNT : PH_MACCESS;
          end
          PH_MCOUNT: begin
            res.item_kind     = KIND_METHODS_COUNT;
            res.owner         = OWN_METHOD;
            ctx_owner_next    = OWN_METHOD;
            members_left_next = v16;
            member_index_next = '0;
            phase_next        = (v16 == '0) ? PH_CACOUNT : PH_MACCESS;
          end
          PH_MACCESS: begin
            res.item_kind    = KIND_MEMBER_ACCESS;
            res.entry_number = member_index;
            res.owner        = ctx_owner;
            phase_next       = PH_MNAME;
          end
          PH_MNAME: begin
            res.item_kind    = KIND_NAME_INDEX;
            res.entry_number = member_index;
            res.owner        = ctx_owner;
            phase_next       = PH_MDESC;
          end
          PH_MDESC: begin
            res.item_kind    = KIND_DESC_INDEX;
            res.entry_number = member_index;
            res.owner        = ctx_owner;
            phase_next       = PH_MACOUNT;
          end
          PH_MACOUNT: begin
            res.item_kind        = KIND_ATTR_COUNT;
            res.entry_number     = member_index;
            res.owner            = ctx_owner;
            attributes_left_next = v16;
            entry_counter_next   = '0;
            if (v16 == '0) begin
              phase_next = ae_phase;
              if (ctx_owner != OWN_CLASS) begin
                member_index_next = mi_inc;
                members_left_next = ml_dec;
              end
            end else begin
              phase_next = PH_ANAME;
            end
          end
          PH_CACOUNT: begin
            res.item_kind        = KIND_ATTR_COUNT;
            res.owner            = OWN_CLASS;
            ctx_owner_next       = OWN_CLASS;
            attributes_left_next = v16;
            entry_counter_next   = '0;
            phase_next           = (v16 == '0) ? PH_DONE : PH_ANAME;
          end
          PH_ANAME: begin
            res.item_kind    = KIND_ATTR_NAME;
            res.entry_number = entry_counter;
            res.owner        = ctx_owner;
            phase_next       = PH_ALEN;
          end
          PH_ALEN: begin
            res.item_kind     = KIND_ATTR_LEN;
            res.entry_number  = entry_counter;
            res.owner         = ctx_owner;
            payload_left_next = acc_sh;
            if (acc_sh == '0) begin
              entry_counter_next   = ec_inc;
              attributes_left_next = al_dec;
              if (al_dec == '0) begin
                phase_next = ae_phase;
                if (ctx_owner != OWN_CLASS) begin
                  member_index_next = mi_inc;
                  members_left_next = ml_dec;
                end
              end else begin
                phase_next = PH_ANAME;
              end
            end else begin
              phase_next = PH_ABYTES;
            end
          end
          PH_ABYTES: begin
            res.item_kind     = KIND_ATTR_BYTE;
            res.entry_number  = entry_counter;
            res.owner         = ctx_owner;
            payload_left_next = pl_dec;
            if (pl_dec == '0) begin
              entry_counter_next   = ec_inc;
              attributes_left_next = al_dec;
              if (al_dec == '0) begin
                phase_next = ae_phase;
                if (ctx_owner != OWN_CLASS) begin
                  member_index_next = mi_inc;
                  members_left_next = ml_dec;
                end
              end else begin
                phase_next = PH_ANAME;
              end
            end
          end
          default: begin
            have           = 1'b0;
            res.item_value = '0;
          end
        endcase
      end else begin
        byte_position_next = bp_inc;
        accumulator_next   = acc_sh;
      end

      if (st != ST_RUNNING) begin
        stopped_next = 1'b1;
      end else if (phase_next == PH_DONE) begin
        st           = ST_FINISHED;
        stopped_next = 1'b1;
      end
    end

    // last byte of the file: report a truncated walk if still running, then start over
    if (accept && beat.end_of_file) begin
      if (!stopped && st == ST_RUNNING) st = ST_CUT_OFF;
      phase_next           = PH_MAGIC;
      byte_position_next   = '0;
      accumulator_next     = '0;
      entries_left_next    = '0;
      entry_counter_next   = '0;
      members_left_next    = '0;
      attributes_left_next = '0;
      member_index_next    = '0;
      payload_left_next    = '0;
      current_tag_next     = '0;
      stopped_next         = 1'b0;
      ctx_owner_next       = OWN_NONE;
    end

    res_valid = accept && !stopped && (have || st != ST_RUNNING);
    if (!have) begin
      res.item_kind    = KIND_STATUS;
      res.item_value   = '0;
      res.entry_number = '0;
      res.owner        = OWN_NONE;
    end
    res.status = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_MAGIC;
      byte_position   <= '0;
      accumulator     <= '0;
      entries_left    <= '0;
      entry_counter   <= '0;
      members_left    <= '0;
      attributes_left <= '0;
      member_index    <= '0;
      payload_left    <= '0;
      current_tag     <= '0;
      stopped         <= 1'b0;
      ctx_owner       <= OWN_NONE;
    end else begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      accumulator     <= accumulator_next;
      entries_left    <= entries_left_next;
      entry_counter   <= entry_counter_next;
      members_left    <= members_left_next;
      attributes_left <= attributes_left_next;
      member_index    <= member_index_next;
      payload_left    <= payload_left_next;
      current_tag     <= current_tag_next;
      stopped         <= stopped_next;
      ctx_owner       <= ctx_owner_next;
    end
  end

endmodule

### rtl/cfsp_out_reg.sv
// Output register holding one decoded item beat
`timescale 1ns / 1ps

module cfsp_out_reg import cfsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  cfsp_out_t load_data,
  input  logic      item_stall,
  output logic      item_valid,
  output cfsp_out_t item_data,
  output logic      busy
);

  assign busy = item_valid && item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (!item_stall) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_data <= load_data;
    end
  end

endmodule

### rtl/class_file_stream_parser.sv
// Top level of the class file stream parser
//
//   channel   | beat type  | handshake
//   ----------+------------+-------------------------
//   byte      | cfsp_in_t  | byte_valid / byte_stall
//   item      | cfsp_out_t | item_valid / item_stall
//
// One byte per cycle while byte_stall is low; a decoded item appears in the cycle after its byte.
// The walker computes the next phase and counters for a byte combinationally.
// byte_stall is high only while a held item is stalled downstream.
// Synchronous reset; bytes can be taken as soon as reset is released.
`timescale 1ns / 1ps

module class_file_stream_parser import cfsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  cfsp_in_t  byte_data,
  output logic      item_valid,
  input  logic      item_stall,
  output cfsp_out_t item_data
);

  logic      accept;
  logic      res_valid;
  cfsp_out_t res;

  assign accept = byte_valid && !byte_stall;

  cfsp_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .beat      (byte_data),
    .res_valid (res_valid),
    .res       (res)
  );

  cfsp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (res_valid),
    .load_data  (res),
    .item_stall (item_stall),
    .item_valid (item_valid),
    .item_data  (item_data),
    .busy       (byte_stall)
  );

endmodule

### rtl/cfsp_checker.sv
// Port-level checker for the class file stream parser, with its bind
`timescale 1ns / 1ps
`include "class_file_stream_parser_assert.svh"

module cfsp_port_checker import cfsp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      byte_stall,
  input logic      item_valid,
  input logic      item_stall,
  input cfsp_out_t item_data
);

  logic item_is_status;
  logic status_fields_clear;
  logic item_bad_magic;
  logic item_finished;
  logic finish_kind;

  assign item_is_status      = item_valid && item_data.item_kind == KIND_STATUS;
  assign status_fields_clear = item_data.item_value == '0 && item_data.entry_number == '0 &&
                               item_data.owner == OWN_NONE && item_data.status != ST_RUNNING;
  assign item_bad_magic      = item_valid && item_data.status == ST_BAD_MAGIC;
  assign item_finished       = item_valid && item_data.status == ST_FINISHED;
  assign finish_kind         = item_data.owner == OWN_CLASS &&
                               (item_data.item_kind == KIND_ATTR_COUNT ||
                                item_data.item_kind == KIND_ATTR_LEN ||
                                item_data.item_kind == KIND_ATTR_BYTE);

  `CFSP_ASSERT_NEXT(a_item_hold, item_valid && item_stall, item_valid && $stable(item_data))
  `CFSP_ASSERT_NOW(a_stall_backs_up, item_valid && item_stall, byte_stall)
  `CFSP_ASSERT_NOW(a_status_only, item_is_status, status_fields_clear)
  `CFSP_ASSERT_NOW(a_bad_magic, item_bad_magic, item_data.item_kind == KIND_MAGIC && item_data.item_value != MAGIC_WORD)
  `CFSP_ASSERT_NOW(a_finish_point, item_finished, finish_kind)

endmodule

bind class_file_stream_parser cfsp_port_checker u_cfsp_checker (.*);
